[hw/rtl/dcb_pkg.sv]
// Shared types and constants for the stereo ADC pairing DC blocker.
package dcb_pkg;

  localparam int DC_SHIFT = 11;
  localparam int Q_SHIFT  = 8;
  localparam int PCM_MAX  = 32767;
  localparam int PCM_MIN  = -32768;

  localparam logic [7:0] GAIN_RST     = 8'd16;
  localparam logic [3:0] LEFT_CH_RST  = 4'd3;
  localparam logic [3:0] RIGHT_CH_RST = 4'd4;

  typedef enum logic [1:0] {
    REG_GAIN     = 2'd0,
    REG_LEFT_CH  = 2'd1,
    REG_RIGHT_CH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] gain;
    logic [3:0] left_ch;
    logic [3:0] right_ch;
  } dcb_cfg_t;

endpackage

[hw/rtl/dcb_pair.sv]
// Pairs a pending left conversion with the next right conversion into a frame.
module dcb_pair #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept_i,
  input  logic [3:0]             channel_i,
  input  logic [SAMPLE_BITS-1:0] value_i,
  input  dcb_pkg::dcb_cfg_t      cfg_i,
  output logic                   frame_o,
  output logic [SAMPLE_BITS-1:0] left_raw_o,
  output logic [SAMPLE_BITS-1:0] right_raw_o
);
  import dcb_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] PEND_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  logic                   have_left_r, have_left_nxt;
  logic [SAMPLE_BITS-1:0] pending_r, pending_nxt;
  logic                   is_left, is_right;
  logic [SAMPLE_BITS-1:0] left_raw_r, right_raw_r;

  // left wins when both channel registers match
  assign is_left  = (channel_i == cfg_i.left_ch);
  assign is_right = !is_left && (channel_i == cfg_i.right_ch);
  assign frame_o  = accept_i && is_right && have_left_r;

  always_comb begin
    have_left_nxt = have_left_r;
    pending_nxt   = pending_r;
    if (accept_i && is_left) begin
      have_left_nxt = 1'b1;
      pending_nxt   = value_i;
    end else if (frame_o) begin
      have_left_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_left_r <= 1'b0;
      pending_r   <= PEND_RST;
    end else begin
      have_left_r <= have_left_nxt;
      pending_r   <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_o) begin
      left_raw_r  <= pending_r;
      right_raw_r <= value_i;
    end
  end

  assign left_raw_o  = left_raw_r;
  assign right_raw_o = right_raw_r;

endmodule

[hw/rtl/dcb_center.sv]
// One side's Q8 DC tracker and centered-value register.
module dcb_center #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en_i,
  input  logic [SAMPLE_BITS-1:0]      raw_i,
  output logic signed [SAMPLE_BITS:0] center_o
);
  import dcb_pkg::*;

  localparam int DW = SAMPLE_BITS + Q_SHIFT;
  localparam int SW = DW + 1;
  localparam logic [DW-1:0] DC_RST = DW'(1) << (DW - 1);

  logic [DW-1:0]               dc_r, dc_nxt;
  logic signed [SW-1:0]        rq, dcs, diff, dc_new, resid;
  logic signed [SAMPLE_BITS:0] center_r;

  always_comb begin
    rq     = signed'({1'b0, raw_i, Q_SHIFT'(0)});
    dcs    = signed'({1'b0, dc_r});
    diff   = rq - dcs;
    dc_new = dcs + (diff >>> DC_SHIFT);
    resid  = rq - dc_new;
    // estimate stays within 0 .. raw max << 8, top bit is always clear
    dc_nxt = dc_new[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= DC_RST;
    end else if (en_i) begin
      dc_r <= dc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      center_r <= resid[SW-1:Q_SHIFT];
    end
  end

  assign center_o = center_r;

endmodule

[hw/rtl/dcb_scale.sv]
// Gain multiply and 16-bit saturation into the result register of one side.
module dcb_scale #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        en_i,
  input  logic signed [SAMPLE_BITS:0] center_i,
  input  logic [7:0]                  gain_i,
  output logic signed [15:0]          pcm_o
);
  import dcb_pkg::*;

  localparam int PW = SAMPLE_BITS + 10;
  localparam logic signed [PW-1:0] SAT_HI = signed'(PW'(PCM_MAX));
  localparam logic signed [PW-1:0] SAT_LO = signed'(PW'(PCM_MIN));

  logic signed [PW-1:0] prod;
  logic signed [15:0]   pcm_nxt;
  logic signed [15:0]   pcm_r;

  always_comb begin
    prod = center_i * signed'({1'b0, gain_i});
    if (prod > SAT_HI) begin
      pcm_nxt = SAT_HI[15:0];
    end else if (prod < SAT_LO) begin
      pcm_nxt = SAT_LO[15:0];
    end else begin
      pcm_nxt = prod[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      pcm_r <= pcm_nxt;
    end
  end

  assign pcm_o = pcm_r;

endmodule

[hw/rtl/stereo_adc_pair_dc_block.sv]
// Top level of the stereo ADC pairing DC blocker.
// Usage:
//   Input requests carry one tagged conversion (channel, raw value). A request
//   on the left channel is held as pending; a right request with a pending left
//   forms one stereo frame. Other requests are absorbed with no result.
//   Results carry left and right 16-bit PCM with DC removed, gain applied and
//   saturation to signed 16 bits.
//   Pipeline: a frame passes the pair register, the DC/centering register and
//   the gain/saturate register, then shows on out_valid; the pair register
//   loads at the edge that takes the right request.
//   Throughput: one request per cycle; each stage forwards whenever the stage
//   after it is empty or moving, so in_stall rises only when all three stages
//   hold frames and out_stall is high.
//   Configuration: APB registers gain (0x0), left channel (0x4) and right
//   channel (0x8); write them only while the block is idle. pready is tied high.
//   Reset: clears the pipeline valid bits and the pending-left mark, sets both
//   DC estimates to mid-scale and the registers to gain 16, left 3, right 4.
//   Stall: a held result keeps out_valid and its data steady until taken.
module stereo_adc_pair_dc_block #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_sample_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_left_pcm,
  output logic signed [15:0]     out_right_pcm,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import dcb_pkg::*;

  dcb_cfg_t cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;

  logic accept, frame;
  logic ready_out, ready_s2, ready_s1;
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv, s2_adv;

  logic [SAMPLE_BITS-1:0]      left_raw, right_raw;
  logic signed [SAMPLE_BITS:0] left_c, right_c;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_GAIN:     cfg_nxt.gain     = pwdata[7:0];
        REG_LEFT_CH:  cfg_nxt.left_ch  = pwdata[3:0];
        REG_RIGHT_CH: cfg_nxt.right_ch = pwdata[3:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:     prdata = {24'd0, cfg_r.gain};
      REG_LEFT_CH:  prdata = {28'd0, cfg_r.left_ch};
      REG_RIGHT_CH: prdata = {28'd0, cfg_r.right_ch};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain     <= GAIN_RST;
      cfg_r.left_ch  <= LEFT_CH_RST;
      cfg_r.right_ch <= RIGHT_CH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline flow control
  assign ready_out = !out_valid_r || !out_stall;
  assign ready_s2  = !s2_valid_r || ready_out;
  assign ready_s1  = !s1_valid_r || ready_s2;
  assign in_stall  = !ready_s1;
  assign accept    = in_valid && ready_s1;
  assign s1_adv    = s1_valid_r && ready_s2;
  assign s2_adv    = s2_valid_r && ready_out;

  always_comb begin
    s1_valid_nxt  = frame ? 1'b1 : (ready_s2 ? 1'b0 : s1_valid_r);
    s2_valid_nxt  = ready_s2 ? s1_valid_r : s2_valid_r;
    out_valid_nxt = ready_out ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  dcb_pair #(.SAMPLE_BITS(SAMPLE_BITS)) u_pair (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .channel_i   (in_sample_channel),
    .value_i     (in_sample_value),
    .cfg_i       (cfg_r),
    .frame_o     (frame),
    .left_raw_o  (left_raw),
    .right_raw_o (right_raw)
  );

  dcb_center #(.SAMPLE_BITS(SAMPLE_BITS)) u_center_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (s1_adv),
    .raw_i    (left_raw),
    .center_o (left_c)
  );

  dcb_center #(.SAMPLE_BITS(SAMPLE_BITS)) u_center_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (s1_adv),
    .raw_i    (right_raw),
    .center_o (right_c)
  );

  dcb_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_l (
    .clk      (clk),
    .en_i     (s2_adv),
    .center_i (left_c),
    .gain_i   (cfg_r.gain),
    .pcm_o    (out_left_pcm)
  );

  dcb_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_r (
    .clk      (clk),
    .en_i     (s2_adv),
    .center_i (right_c),
    .gain_i   (cfg_r.gain),
    .pcm_o    (out_right_pcm)
  );

endmodule

[hw/rtl/dcb_checker.sv]
// Port-level checks for the stereo ADC pairing DC blocker, bound to the top level.
module dcb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_left_pcm,
  input logic signed [15:0] out_right_pcm
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_pcm) && $stable(out_right_pcm))
    else $error("result data changed while stalled");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result must follow a request that was taken earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without a matching request");

endmodule

bind stereo_adc_pair_dc_block dcb_checker u_dcb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left_pcm  (out_left_pcm),
  .out_right_pcm (out_right_pcm)
);

[tb/stereo_adc_pair_dc_block_tb.sv]
// Self-checking testbench for the stereo ADC pairing DC blocker.
module stereo_adc_pair_dc_block_tb;
  import dcb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DC_MID         = 2048 << Q_SHIFT;

  typedef struct packed {
    logic signed [15:0] left_pcm;
    logic signed [15:0] right_pcm;
  } frame_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_sample_channel;
  logic [11:0]        in_sample_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_left_pcm;
  logic signed [15:0] out_right_pcm;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state: register shadow, pending left sample, DC estimates.
  dcb_cfg_t    cfg_shadow;
  logic [11:0] held_left;
  bit          left_held;
  int          dc_l;
  int          dc_r;
  frame_t      frames_due[$];

  int errors       = 0;
  int quiet_cycles = 0;
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  int rx_hold      = 0;
  int rx_wait      = 0;

  stereo_adc_pair_dc_block u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_channel (in_sample_channel),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_pcm      (out_left_pcm),
    .out_right_pcm     (out_right_pcm),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  // Advance one side's DC estimate, then center, scale and clamp.
  function automatic logic signed [15:0] center_side(input logic [11:0] raw, inout int dc,
                                                     input logic [7:0] g);
    int rq;
    int c;
    int p;
    rq = int'(raw) << Q_SHIFT;
    dc = dc + ((rq - dc) >>> DC_SHIFT);
    c  = (rq - dc) >>> Q_SHIFT;
    p  = c * int'(g);
    if (p > PCM_MAX) p = PCM_MAX;
    else if (p < PCM_MIN) p = PCM_MIN;
    return p[15:0];
  endfunction

  function automatic void predict_sample(input logic [3:0] ch, input logic [11:0] val);
    frame_t f;
    if (ch == cfg_shadow.left_ch) begin
      held_left = val;
      left_held = 1'b1;
    end else if (ch == cfg_shadow.right_ch && left_held) begin
      f.left_pcm  = center_side(held_left, dc_l, cfg_shadow.gain);
      f.right_pcm = center_side(val, dc_r, cfg_shadow.gain);
      frames_due.push_back(f);
      left_held = 1'b0;
    end
  endfunction

  function automatic logic [11:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Valid is lowered only when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_sample(input logic [3:0] ch, input logic [11:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_channel <= ch;
    in_sample_value   <= val;
    do @(posedge clk); while (in_stall);
    predict_sample(ch, val);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN:     cfg_shadow.gain     = value[7:0];
      REG_LEFT_CH:  cfg_shadow.left_ch  = value[3:0];
      REG_RIGHT_CH: cfg_shadow.right_ch = value[3:0];
      default: ;
    endcase
    // leave the bus idle before the next write
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] g, input logic [3:0] l, input logic [3:0] r);
    wait_idle();
    write_reg(REG_GAIN, {24'd0, g});
    write_reg(REG_LEFT_CH, {28'd0, l});
    write_reg(REG_RIGHT_CH, {28'd0, r});
  endtask

  // Mostly left/right pairs with random content; the rest is noise and broken pairs.
  task automatic run_stream(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_sample(cfg_shadow.left_ch, rand_raw());
        send_sample(cfg_shadow.right_ch, rand_raw());
        sent += 2;
      end else begin
        if (pick < 83) send_sample(cfg_shadow.left_ch, rand_raw());
        else if (pick < 90) send_sample(cfg_shadow.right_ch, rand_raw());
        else send_sample(4'($urandom_range(0, 15)), rand_raw());
        sent += 1;
      end
    end
  endtask

  task automatic test_directed();
    logic [3:0] l;
    logic [3:0] r;
    l = cfg_shadow.left_ch;
    r = cfg_shadow.right_ch;
    send_sample(r, 12'd100);       // right with nothing pending: drop
    send_sample(4'd0, 12'd4095);   // foreign channels: ignore
    send_sample(4'd15, 12'd0);
    send_sample(l, 12'd0);         // second left replaces the first
    send_sample(l, 12'd4095);
    send_sample(r, 12'd0);
    send_sample(l, 12'd4095);
    send_sample(r, 12'd4095);
    send_sample(l, 12'd0);
    send_sample(r, 12'd0);
    send_sample(l, 12'd2048);
    send_sample(4'd9, 12'd1234);   // foreign channel between left and right
    send_sample(r, 12'd2048);
    send_sample(r, 12'd7);
    send_sample(l, 12'd2047);
    send_sample(r, 12'd2049);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_config(8'd255, 4'd0, 4'd15);
    run_stream(40);
    set_config(8'd0, 4'd15, 4'd0);
    run_stream(40);
    set_config(8'd1, 4'd7, 4'd8);
    run_stream(40);
    // equal channel registers: every matching sample is taken as left
    set_config(8'd200, 4'd5, 4'd5);
    run_stream(40);
    set_config(GAIN_RST, LEFT_CH_RST, RIGHT_CH_RST);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 120;
    run_stream(40);
    wait_idle();
    tx_idle = 1'b1;
  endtask

  task automatic test_random();
    logic [3:0] l;
    logic [3:0] r;
    for (int chunk = 0; chunk < 6; chunk++) begin
      l = 4'($urandom_range(0, 15));
      do r = 4'($urandom_range(0, 15)); while (r == l);
      set_config(8'($urandom_range(0, 255)), l, r);
      tx_idle = (chunk % 4) != 1 && (chunk % 4) != 3;
      rx_idle = (chunk % 4) != 2 && (chunk % 4) != 3;
      run_stream(75);
    end
    wait_idle();
  endtask

  // Result side: per-frame stall draw plus an externally requested long hold.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t unexpected frame: left_pcm %0d right_pcm %0d",
                 $time, out_left_pcm, out_right_pcm);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (out_left_pcm !== want.left_pcm) begin
          $display("%0t left_pcm mismatch: expected %0d, got %0d",
                   $time, want.left_pcm, out_left_pcm);
          errors++;
        end
        if (out_right_pcm !== want.right_pcm) begin
          $display("%0t right_pcm mismatch: expected %0d, got %0d",
                   $time, want.right_pcm, out_right_pcm);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_sample_channel = 4'd0;
    in_sample_value   = 12'd0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 4'd0;
    pwdata            = 32'd0;
    cfg_shadow.gain     = GAIN_RST;
    cfg_shadow.left_ch  = LEFT_CH_RST;
    cfg_shadow.right_ch = RIGHT_CH_RST;
    held_left = 12'd2048;
    left_held = 1'b0;
    dc_l      = DC_MID;
    dc_r      = DC_MID;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    wait_idle();

    if (frames_due.size() != 0) begin
      $display("%0t %0d expected frames never arrived", $time, frames_due.size());
      errors++;
    end
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
